>>> hw/rtl/vadc_pkg.sv
// ---------------------------------------------------------------------------
// vadc_pkg
// Types and constants shared by the VCO amplitude DAC controller files.
// ---------------------------------------------------------------------------
package vadc_pkg;

   // opcodes of an input item
   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_START  = 2'd1;
   localparam logic [1:0] OP_SAMPLE = 2'd2;
   localparam logic [1:0] OP_TRACK  = 2'd3;

   // temperature levels
   localparam logic [1:0] TEMP_LOW  = 2'd1;
   localparam logic [1:0] TEMP_HIGH = 2'd2;

   // hold selections that force a tracking direction
   localparam logic [3:0] HOLD_MIN = 4'd0;
   localparam logic [3:0] HOLD_MAX = 4'd11;

   // dac codes, coarse in bits 7..5 and fine in bits 4..0
   localparam logic [7:0] DAC_RESET  = 8'h8f;   // coarse 4, fine 15
   localparam logic [7:0] DAC_RELOAD = 8'h70;   // coarse 3, fine 16
   localparam logic [7:0] DAC_MIN    = 8'h00;
   localparam logic [7:0] DAC_MAX    = 8'hff;

   localparam logic [7:0] STEP_RESET   = 8'd8;
   localparam logic [3:0] HIST_LOCK    = 4'b0101;
   localparam logic [1:0] FAIL_LIMIT   = 2'd3;

   typedef struct packed {
      logic [1:0] opcode;
      logic       amp_high;
      logic [1:0] temp_level;
      logic [3:0] hold_select;
      logic [7:0] dac_value;
   } vadc_req_type;

   typedef struct packed {
      logic [2:0] dac_coarse_out;
      logic [4:0] dac_fine_out;
      logic       search_active;
      logic       search_ok;
      logic [7:0] track_count;
   } vadc_rsp_type;

   typedef struct packed {
      logic [7:0] dac;
      logic [7:0] track_counter;
      logic [3:0] sample_history;
      logic [1:0] low_fail_count;
      logic [1:0] high_fail_count;
      logic       searching;
      logic       search_passed;
   } vadc_state_type;

endpackage

>>> hw/rtl/vadc_core.sv
// ---------------------------------------------------------------------------
// vadc_core
// Next state of the DAC controller for one item, and the result it shows.
// ---------------------------------------------------------------------------
module vadc_core (
   input  vadc_pkg::vadc_req_type   item,
   input  vadc_pkg::vadc_state_type state,
   input  logic [7:0]               track_step,
   output vadc_pkg::vadc_state_type next_state,
   output vadc_pkg::vadc_rsp_type   result
);
   import vadc_pkg::*;

   vadc_state_type base;
   logic [3:0]     hist;
   logic [1:0]     fail_inc;
   logic [7:0]     cnt;
   logic           hit;
   logic           go_down;
   logic           go_up;

   always_comb begin
      next_state = state;
      base       = state;
      hist       = 4'd0;
      fail_inc   = 2'd0;
      cnt        = 8'd0;
      hit        = 1'b0;
      go_down    = 1'b0;
      go_up      = 1'b0;

      unique case (item.opcode) inside
         OP_LOAD: begin
            next_state.dac = item.dac_value;
         end
         OP_START, OP_SAMPLE: begin
            if (item.opcode == OP_START) begin
               base.sample_history  = 4'd0;
               base.low_fail_count  = 2'd0;
               base.high_fail_count = 2'd0;
               base.searching       = 1'b1;
               base.search_passed   = 1'b1;
            end
            if (base.searching) begin
               next_state = base;
               hist = {base.sample_history[2:0], item.amp_high};
               next_state.sample_history = hist;
               if (hist == HIST_LOCK) begin
                  next_state.searching = 1'b0;
               end else if (item.amp_high) begin
                  if (base.dac != DAC_MIN) begin
                     next_state.dac = base.dac - 8'd1;
                  end else begin
                     // bottom end: restart from mid code, count a low failure
                     next_state.dac = DAC_RELOAD;
                     fail_inc = base.low_fail_count + 2'd1;
                     next_state.low_fail_count = fail_inc;
                     if (fail_inc == FAIL_LIMIT) begin
                        next_state.searching     = 1'b0;
                        next_state.search_passed = 1'b0;
                     end
                  end
               end else begin
                  if (base.dac != DAC_MAX) begin
                     next_state.dac = base.dac + 8'd1;
                  end else begin
                     fail_inc = base.high_fail_count + 2'd1;
                     next_state.high_fail_count = fail_inc;
                     if (fail_inc == FAIL_LIMIT) begin
                        next_state.searching     = 1'b0;
                        next_state.search_passed = 1'b0;
                     end
                  end
               end
            end
         end
         default: begin
            cnt = item.amp_high ? state.track_counter - 8'd1 : state.track_counter + 8'd1;
            hit = ({1'b0, cnt} >= {track_step, 1'b0}) || (cnt == 8'd0);
            next_state.track_counter = cnt;
            if (hit) begin
               next_state.track_counter = track_step;
               if (item.temp_level == TEMP_HIGH && item.hold_select == HOLD_MAX
                   && item.amp_high) begin
                  go_down = 1'b1;
               end else if (item.temp_level == TEMP_LOW && item.hold_select == HOLD_MIN) begin
                  go_up = 1'b1;
               end else begin
                  go_up = !item.amp_high;
               end
               if (go_down && state.dac != DAC_MIN) begin
                  next_state.dac = state.dac - 8'd1;
               end else if (go_up && state.dac != DAC_MAX) begin
                  next_state.dac = state.dac + 8'd1;
               end
            end
         end
      endcase

      result.dac_coarse_out = next_state.dac[7:5];
      result.dac_fine_out   = next_state.dac[4:0];
      result.search_active  = next_state.searching;
      result.search_ok      = next_state.search_passed;
      result.track_count    = next_state.track_counter;
   end

endmodule

>>> hw/rtl/vco_amplitude_dac_controller_unit.sv
// ---------------------------------------------------------------------------
// vco_amplitude_dac_controller_unit
// VCO amplitude DAC controller: load, search and tracking of the DAC code.
// ---------------------------------------------------------------------------
// usage
//   req channel: one item per opcode (load, start search, search sample,
//   tracking tick) with the comparator sample and temperature inputs
//   rsp channel: one item per request, the DAC code, search flags and
//   tracking count as they stand after that request
//   csr port: write of the tracking step size, used from the next edge on;
//   write it only while no item is in flight
// timing
//   an item taken at edge n has its result valid after edge n+1: one input
//   register, then the state update and result register in one pass
//   throughput is one item per cycle; the state registers close a one-cycle
//   loop through the update logic, so items follow back to back
// reset
//   synchronous; dac returns to coarse 4 / fine 15, step size to 8, the
//   tracking count to 8, search idle and passed, both stages empty
// stall
//   a stalled result holds in the output register; the input register keeps
//   one more item, and req_stall rises only when both are full
// ---------------------------------------------------------------------------
module vco_amplitude_dac_controller_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  vadc_pkg::vadc_req_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output vadc_pkg::vadc_rsp_type rsp_item,
   input  logic                   csr_wr_en,
   input  logic [7:0]             csr_wr_data
);
   import vadc_pkg::*;

   // input stage
   logic           s1_valid_ff, s1_valid_in;
   vadc_req_type   s1_item_ff;
   // controller state and config
   vadc_state_type state_ff, state_in;
   logic [7:0]     step_ff, step_in;
   // output stage
   logic           rsp_valid_ff, rsp_valid_in;
   vadc_rsp_type   rsp_item_ff, rsp_item_in;

   logic accept;
   logic out_free;
   logic advance;

   vadc_core u_core (
      .item       (s1_item_ff),
      .state      (state_ff),
      .track_step (step_ff),
      .next_state (state_in),
      .result     (rsp_item_in)
   );

   // output register can load when empty or being drained this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   assign s1_valid_in  = accept || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
   assign step_in      = csr_wr_en ? csr_wr_data : step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= STEP_RESET;
         state_ff.dac             <= DAC_RESET;
         state_ff.track_counter   <= STEP_RESET;
         state_ff.sample_history  <= 4'd0;
         state_ff.low_fail_count  <= 2'd0;
         state_ff.high_fail_count <= 2'd0;
         state_ff.searching       <= 1'b0;
         state_ff.search_passed   <= 1'b1;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
         // state moves only when an item leaves the input stage
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= req_item;
      end
      if (advance) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

>>> hw/rtl/vadc_checker.sv
// ---------------------------------------------------------------------------
// vadc_checker
// Port-level checks of the DAC controller, bound to the top level.
// ---------------------------------------------------------------------------
module vadc_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input vadc_pkg::vadc_rsp_type rsp_item
);
   import vadc_pkg::*;

   // a held result does not change
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("stalled result changed");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // a failed search is never still running
   a_fail_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_item.search_active && !rsp_item.search_ok))
      else $error("search active after failure");

   // input backpressure only when the output is blocked
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled with output free");

endmodule

bind vco_amplitude_dac_controller_unit vadc_checker u_vadc_checker (.*);

>>> bench/vadc_status_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// vadc_status_checker
// Tracks the DAC controller state from the accepted request items and
// compares every accepted result item against the predicted status.
// ---------------------------------------------------------------------------
module vadc_status_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  vadc_pkg::vadc_req_type req_item,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  vadc_pkg::vadc_rsp_type rsp_item,
   input  logic                   csr_wr_en,
   input  logic [7:0]             csr_wr_data,
   output int                     fail_count,
   output int                     pending_count
);
   import vadc_pkg::*;

   localparam int PRINT_LIMIT = 40;

   // predicted controller state
   logic [7:0] track_step;
   logic [2:0] coarse;
   logic [4:0] fine;
   logic [7:0] track_cnt;
   logic [3:0] history;
   logic [1:0] low_fails;
   logic [1:0] high_fails;
   logic       searching;
   logic       passed;

   vadc_rsp_type status_q[$];
   vadc_rsp_type want;
   int           mismatches = 0;

   task automatic report_mismatch(input string msg);
      if (mismatches < PRINT_LIMIT)
         $display("%0t mismatch: %s", $realtime, msg);
      mismatches++;
   endtask

   task automatic reset_state();
      track_step = STEP_RESET;
      {coarse, fine} = DAC_RESET;
      track_cnt  = STEP_RESET;
      history    = '0;
      low_fails  = '0;
      high_fails = '0;
      searching  = 1'b0;
      passed     = 1'b1;
   endtask

   // one code down with borrow, refused at the bottom
   function automatic bit dac_down();
      if ({coarse, fine} == DAC_MIN)
         return 1'b0;
      if (fine == '0) begin
         coarse = coarse - 3'd1;
         fine   = '1;
      end else begin
         fine = fine - 5'd1;
      end
      return 1'b1;
   endfunction

   // one code up with carry, refused at the top
   function automatic bit dac_up();
      if ({coarse, fine} == DAC_MAX)
         return 1'b0;
      if (fine == '1) begin
         coarse = coarse + 3'd1;
         fine   = '0;
      end else begin
         fine = fine + 5'd1;
      end
      return 1'b1;
   endfunction

   function automatic void search_sample(input logic amp);
      history = {history[2:0], amp};
      if (history == HIST_LOCK) begin
         searching = 1'b0;
         return;
      end
      if (amp) begin
         if (!dac_down()) begin
            {coarse, fine} = DAC_RELOAD;
            low_fails = low_fails + 2'd1;
            if (low_fails == FAIL_LIMIT) begin
               passed    = 1'b0;
               searching = 1'b0;
            end
         end
      end else if (!dac_up()) begin
         high_fails = high_fails + 2'd1;
         if (high_fails == FAIL_LIMIT) begin
            passed    = 1'b0;
            searching = 1'b0;
         end
      end
   endfunction

   function automatic void track_tick(input logic amp, input logic [1:0] temp,
                                      input logic [3:0] hold);
      track_cnt = amp ? track_cnt - 8'd1 : track_cnt + 8'd1;
      // count still inside its window: no adjustment
      if ({1'b0, track_cnt} < {track_step, 1'b0} && track_cnt != '0)
         return;
      track_cnt = track_step;
      if (temp == TEMP_HIGH && hold == HOLD_MAX && amp)
         void'(dac_down());
      else if (temp == TEMP_LOW && hold == HOLD_MIN)
         void'(dac_up());
      else if (!amp)
         void'(dac_up());
   endfunction

   function automatic vadc_rsp_type advance_controller(input vadc_req_type it);
      vadc_rsp_type st;
      case (it.opcode)
         OP_LOAD: begin
            {coarse, fine} = it.dac_value;
         end
         OP_START: begin
            history    = '0;
            low_fails  = '0;
            high_fails = '0;
            searching  = 1'b1;
            passed     = 1'b1;
            search_sample(it.amp_high);
         end
         OP_SAMPLE: begin
            if (searching)
               search_sample(it.amp_high);
         end
         OP_TRACK: begin
            track_tick(it.amp_high, it.temp_level, it.hold_select);
         end
      endcase
      st.dac_coarse_out = coarse;
      st.dac_fine_out   = fine;
      st.search_active  = searching;
      st.search_ok      = passed;
      st.track_count    = track_cnt;
      return st;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         reset_state();
         status_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (status_q.size() == 0) begin
               report_mismatch($sformatf("result %h with none expected", rsp_item));
            end else begin
               want = status_q.pop_front();
               if (rsp_item.dac_coarse_out !== want.dac_coarse_out)
                  report_mismatch($sformatf("dac_coarse_out %0d, expected %0d",
                     rsp_item.dac_coarse_out, want.dac_coarse_out));
               if (rsp_item.dac_fine_out !== want.dac_fine_out)
                  report_mismatch($sformatf("dac_fine_out %0d, expected %0d",
                     rsp_item.dac_fine_out, want.dac_fine_out));
               if (rsp_item.search_active !== want.search_active)
                  report_mismatch($sformatf("search_active %b, expected %b",
                     rsp_item.search_active, want.search_active));
               if (rsp_item.search_ok !== want.search_ok)
                  report_mismatch($sformatf("search_ok %b, expected %b",
                     rsp_item.search_ok, want.search_ok));
               if (rsp_item.track_count !== want.track_count)
                  report_mismatch($sformatf("track_count %0d, expected %0d",
                     rsp_item.track_count, want.track_count));
            end
         end
         if (csr_wr_en)
            track_step = csr_wr_data;
         if (req_valid && !req_stall)
            status_q.push_back(advance_controller(req_item));
      end
      fail_count    <= mismatches;
      pending_count <= status_q.size();
   end

endmodule

>>> bench/tb_vco_amplitude_dac_controller_unit.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_vco_amplitude_dac_controller_unit
// Drives load, search and tracking items into the DAC controller under
// random idling on both channels and several step sizes; a separate checker
// predicts every result item and counts mismatches.
// ---------------------------------------------------------------------------
module tb_vco_amplitude_dac_controller_unit;
   import vadc_pkg::*;

   localparam int HALF_PERIOD     = 10;
   localparam int RESET_CYCLES    = 7;
   localparam int WATCHDOG_LIMIT  = 2000;  // quiet cycles before giving up
   localparam int PRESSURE_CYCLES = 60;    // long receiver hold-off
   localparam int SETTLE_CYCLES   = 6;     // two-stage pipe plus margin
   localparam int PHASE_ITEMS     = 150;
   localparam int NUM_PHASES      = 6;

   logic         clock       = 1'b0;
   logic         reset       = 1'b1;
   logic         req_valid   = 1'b0;
   logic         req_stall;
   vadc_req_type req_item    = '0;
   logic         rsp_valid;
   logic         rsp_stall   = 1'b0;
   vadc_rsp_type rsp_item;
   logic         csr_wr_en   = 1'b0;
   logic [7:0]   csr_wr_data = '0;

   // knobs shared between the stimulus and the receiver process
   bit req_idling   = 1'b1;
   bit rsp_idling   = 1'b1;
   bit hold_request = 1'b0;

   int fail_count;
   int pending_count;
   int quiet_cycles;

   always #HALF_PERIOD clock = ~clock;

   vco_amplitude_dac_controller_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   vadc_status_checker status_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_item      (req_item),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_item      (rsp_item),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // ------------------------------------------------------------------------
   // helpers for building items
   // ------------------------------------------------------------------------

   function automatic vadc_req_type make_item(input logic [1:0] op, input logic amp,
                                              input logic [1:0] temp,
                                              input logic [3:0] hold,
                                              input logic [7:0] code);
      vadc_req_type it;
      it.opcode      = op;
      it.amp_high    = amp;
      it.temp_level  = temp;
      it.hold_select = hold;
      it.dac_value   = code;
      return it;
   endfunction

   function automatic vadc_req_type random_item();
      return make_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                       2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                       8'($urandom_range(0, 255)));
   endfunction

   // dac codes lean toward both ends so that failed steps happen often
   function automatic logic [7:0] pick_dac_code();
      case ($urandom_range(0, 3))
         0:       return DAC_MIN + 8'($urandom_range(0, 2));
         1:       return DAC_MAX - 8'($urandom_range(0, 2));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // 0 even, 1 mostly above threshold, 2 mostly below
   function automatic logic biased_amp(input int bias);
      case (bias)
         1:       return $urandom_range(0, 7) != 0;
         2:       return $urandom_range(0, 7) == 0;
         default: return 1'($urandom_range(0, 1));
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------

   // offer one item and hold it until it is taken; valid is only dropped
   // for an idle burst, so it never toggles within one step
   task automatic send(input vadc_req_type it);
      if (req_idling && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // stop offering and wait until every expected result item has arrived
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // step size write, only ever issued with the block empty
   task automatic write_step(input logic [7:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic run_random(input int count);
      int           sent;
      int           kind;
      int           bias;
      int           len;
      vadc_req_type it;
      sent = 0;
      while (sent < count) begin
         kind = $urandom_range(0, 9);
         if (kind <= 3) begin
            // search run: optional load, start, then samples; loads dropped in
            // between push the dac toward the ends while the search keeps going
            if ($urandom_range(0, 1)) begin
               it = random_item();
               it.opcode    = OP_LOAD;
               it.dac_value = pick_dac_code();
               send(it);
               sent++;
            end
            bias = $urandom_range(0, 2);
            len  = $urandom_range(1, 12);
            for (int k = 0; k <= len; k++) begin
               it = random_item();
               it.opcode   = (k == 0) ? OP_START : OP_SAMPLE;
               it.amp_high = biased_amp(bias);
               if (k != 0 && $urandom_range(0, 3) == 0) begin
                  it.opcode    = OP_LOAD;
                  it.dac_value = pick_dac_code();
               end
               send(it);
               sent++;
            end
         end else if (kind <= 6) begin
            // tracking run, mostly biased so the count leaves its window
            bias = $urandom_range(0, 2);
            len  = $urandom_range(1, 30);
            for (int k = 0; k < len; k++) begin
               it = random_item();
               it.opcode   = OP_TRACK;
               it.amp_high = biased_amp(bias);
               case ($urandom_range(0, 3))
                  0: begin
                     it.temp_level  = TEMP_HIGH;
                     it.hold_select = HOLD_MAX;
                  end
                  1: begin
                     it.temp_level  = TEMP_LOW;
                     it.hold_select = HOLD_MIN;
                  end
                  default: ;
               endcase
               send(it);
               sent++;
            end
         end else if (kind == 7) begin
            it = random_item();
            it.opcode    = OP_LOAD;
            it.dac_value = pick_dac_code();
            send(it);
            sent++;
         end else begin
            // noise: any opcode, any field values
            send(random_item());
            sent++;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // result side: random stall bursts, plus one long hold-off on request
   // ------------------------------------------------------------------------
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            // sender keeps going, so both stages fill and req_stall rises
            rsp_stall <= 1'b1;
            repeat (PRESSURE_CYCLES) @(posedge clock);
            rsp_stall    <= 1'b0;
            hold_request = 1'b0;
         end else if (rsp_idling && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // watchdog: too long without any accepted item ends the run
   // ------------------------------------------------------------------------
   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || csr_wr_en || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("[vco_amplitude_dac_controller_unit] ERROR");
      $finish;
   end

   // ------------------------------------------------------------------------
   // stimulus and verdict
   // ------------------------------------------------------------------------
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // search at the top: three refused increments end it as failed
      send(make_item(OP_LOAD,   1'b0, 2'd0, 4'd0, DAC_MAX));
      send(make_item(OP_START,  1'b0, 2'd0, 4'd0, 8'd0));
      send(make_item(OP_SAMPLE, 1'b0, 2'd0, 4'd0, 8'd0));
      send(make_item(OP_SAMPLE, 1'b0, 2'd0, 4'd0, 8'd0));
      // sample with no search running is ignored
      send(make_item(OP_SAMPLE, 1'b1, 2'd3, 4'd15, DAC_MAX));
      // search at the bottom: each refused decrement reloads coarse 3 / fine 16,
      // loads mid-search pull it back down until three failures
      send(make_item(OP_LOAD,   1'b0, 2'd0, 4'd0, DAC_MIN));
      send(make_item(OP_START,  1'b1, 2'd0, 4'd0, 8'd0));
      send(make_item(OP_LOAD,   1'b0, 2'd0, 4'd0, DAC_MIN));
      send(make_item(OP_SAMPLE, 1'b1, 2'd0, 4'd0, 8'd0));
      send(make_item(OP_LOAD,   1'b0, 2'd0, 4'd0, DAC_MIN));
      send(make_item(OP_SAMPLE, 1'b1, 2'd0, 4'd0, 8'd0));
      // borrow into fine 31, carry back out, then the 0101 pattern locks
      send(make_item(OP_LOAD,   1'b0, 2'd0, 4'd0, 8'h20));
      send(make_item(OP_START,  1'b1, 2'd0, 4'd0, 8'd0));
      send(make_item(OP_SAMPLE, 1'b0, 2'd0, 4'd0, 8'd0));
      send(make_item(OP_SAMPLE, 1'b1, 2'd0, 4'd0, 8'd0));

      // step size 1: every tick leaves the window, so each one takes a step decision
      write_step(8'd1);
      send(make_item(OP_TRACK, 1'b0, 2'd3, 4'd15, DAC_MAX));
      send(make_item(OP_TRACK, 1'b1, TEMP_HIGH, HOLD_MAX, 8'd0));      // forced down
      send(make_item(OP_TRACK, 1'b1, TEMP_LOW, HOLD_MIN, 8'd0));       // forced up
      send(make_item(OP_TRACK, 1'b1, TEMP_HIGH, 4'd10, 8'd0));         // no step
      send(make_item(OP_TRACK, 1'b0, TEMP_HIGH, HOLD_MAX, 8'd0));      // up on low sample
      send(make_item(OP_LOAD,  1'b0, 2'd0, 4'd0, DAC_MAX));
      send(make_item(OP_TRACK, 1'b0, 2'd0, 4'd0, 8'd0));               // refused up
      send(make_item(OP_LOAD,  1'b0, 2'd0, 4'd0, DAC_MIN));
      send(make_item(OP_TRACK, 1'b1, TEMP_HIGH, HOLD_MAX, 8'd0));      // refused down

      // random phases across the step size range, extremes first
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0:       write_step(8'd255);
            1:       write_step(8'd0);
            2:       write_step(8'd1);
            3:       write_step(8'($urandom_range(2, 12)));
            4:       write_step(8'($urandom_range(0, 255)));
            default: write_step(STEP_RESET);
         endcase
         if (ph == 0)
            hold_request = 1'b1;
         // last phase runs at full rate on both sides
         if (ph == NUM_PHASES - 1) begin
            req_idling = 1'b0;
            rsp_idling = 1'b0;
         end
         run_random(PHASE_ITEMS);
      end

      drain();
      if (fail_count == 0)
         $display("[vco_amplitude_dac_controller_unit] OK");
      else
         $display("[vco_amplitude_dac_controller_unit] ERROR");
      $finish;
   end

endmodule
